// ----- sv/tiled_background_pixel_fetch_unit_assert.svh -----
// Assertion macros for the tiled background pixel fetch unit.
// Used by the port checker; no other dependencies.
`ifndef TILED_BACKGROUND_PIXEL_FETCH_UNIT_ASSERT_SVH
`define TILED_BACKGROUND_PIXEL_FETCH_UNIT_ASSERT_SVH

// same-cycle implication
`define TBPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbpf assertion failed");

// next-cycle implication
`define TBPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbpf assertion failed");

`endif

// ----- sv/tbpf_pkg.sv -----
// Shared types, constants and tables for the tiled background pixel fetch unit.
// No dependencies.
package tbpf_pkg;

    localparam int VRAM_BYTES_DEF = 131072;
    localparam int MEM_ADDR_W     = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;
    localparam int RECIP_W        = 14;
    localparam int RECIP_SHIFT    = 13;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_DIMS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX8_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOSAIC_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOSAIC_SIZE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y      = 3'd7;

    // ceil(2^13 / d) for block size d = index + 1; exact quotient for 9-bit values
    localparam logic [RECIP_W-1:0] MOSAIC_RECIP [16] = '{
        14'd8192, 14'd4096, 14'd2731, 14'd2048,
        14'd1639, 14'd1366, 14'd1171, 14'd1024,
        14'd911,  14'd820,  14'd745,  14'd683,
        14'd631,  14'd586,  14'd547,  14'd512
    };

    typedef struct packed {
        logic [1:0] char_base;
        logic [4:0] screen_base;
        logic [1:0] map_dims;
        logic       pix8_mode;
        logic       mosaic_enable;
        logic [7:0] mosaic_size;
        logic [8:0] scroll_x;
        logic [8:0] scroll_y;
    } t_cfg;

    typedef enum logic [1:0] {
        RD_MAP_LO = 2'd0,
        RD_MAP_HI = 2'd1,
        RD_TILE   = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    wr_en;
        logic    mul_en;
        logic    snap_en;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    lo_en;
        logic    hi_en;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- sv/tbpf_cfg.sv -----
// Configuration register file of the pixel fetch unit.
// Depends on tbpf_pkg.
module tbpf_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tbpf_pkg::t_cfg                    o_cfg
);

    tbpf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tbpf_pkg::CFG_CHAR_BASE:     r_cfg.char_base     <= i_cfg_data[1:0];
                tbpf_pkg::CFG_SCREEN_BASE:   r_cfg.screen_base   <= i_cfg_data[4:0];
                tbpf_pkg::CFG_MAP_DIMS:      r_cfg.map_dims      <= i_cfg_data[1:0];
                tbpf_pkg::CFG_PIX8_MODE:     r_cfg.pix8_mode     <= i_cfg_data[0];
                tbpf_pkg::CFG_MOSAIC_ENABLE: r_cfg.mosaic_enable <= i_cfg_data[0];
                tbpf_pkg::CFG_MOSAIC_SIZE:   r_cfg.mosaic_size   <= i_cfg_data[7:0];
                tbpf_pkg::CFG_SCROLL_X:      r_cfg.scroll_x      <= i_cfg_data[8:0];
                tbpf_pkg::CFG_SCROLL_Y:      r_cfg.scroll_y      <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/tbpf_ctrl.sv -----
// Sequencer of the pixel fetch unit: steps one fetch through mosaic snap,
// two map byte reads, one tile byte read and the output load. Depends on tbpf_pkg.
module tbpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    output logic              o_in_ready,
    input  tbpf_pkg::t_status i_status,
    output tbpf_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_SNAP   = 7'b0000100,
        S_MAP_LO = 7'b0001000,
        S_MAP_HI = 7'b0010000,
        S_TILE   = 7'b0100000,
        S_PIX    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = tbpf_pkg::RD_MAP_LO;
        case (r_state)
            S_IDLE: begin
                o_cmd.load  = accept;
                o_cmd.wr_en = accept && (i_operation == tbpf_pkg::OP_WRITE);
                if (accept && (i_operation == tbpf_pkg::OP_FETCH)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SNAP;
            end
            S_SNAP: begin
                o_cmd.snap_en = 1'b1;
                n_state       = S_MAP_LO;
            end
            S_MAP_LO: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tbpf_pkg::RD_MAP_LO;
                n_state      = S_MAP_HI;
            end
            S_MAP_HI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tbpf_pkg::RD_MAP_HI;
                o_cmd.lo_en  = 1'b1;
                n_state      = S_TILE;
            end
            S_TILE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tbpf_pkg::RD_TILE;
                o_cmd.hi_en  = 1'b1;
                n_state      = S_PIX;
            end
            S_PIX: begin
                // hold the tile byte until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/tbpf_dp.sv -----
// Datapath of the pixel fetch unit: video memory, mosaic snap, scroll wrap,
// map and tile address generation, pixel decode and output register. Depends on tbpf_pkg.
module tbpf_dp #(
    parameter int VRAM_BYTES = tbpf_pkg::VRAM_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbpf_pkg::t_cfg                     i_cfg,
    input  tbpf_pkg::t_cmd                     i_cmd,
    output tbpf_pkg::t_status                  o_status,
    input  logic [8:0]                         i_pixel_x,
    input  logic [7:0]                         i_pixel_y,
    input  logic [tbpf_pkg::MEM_ADDR_W-1:0]    i_mem_address,
    input  logic [7:0]                         i_mem_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_pal_entry
);

    localparam int AW = $clog2(VRAM_BYTES);
    localparam int EW = tbpf_pkg::MEM_ADDR_W + 1;

    // addresses never reach twice the memory size, so one subtract wraps them
    function automatic logic [AW-1:0] wrap_addr(input logic [tbpf_pkg::MEM_ADDR_W-1:0] a);
        logic [EW-1:0] e;
        e = {1'b0, a};
        if (e >= EW'(VRAM_BYTES)) begin
            e = e - EW'(VRAM_BYTES);
        end
        return e[AW-1:0];
    endfunction

    logic [7:0]    r_mem [VRAM_BYTES];
    logic [7:0]    r_rdata;
    logic [8:0]    r_px;
    logic [7:0]    r_py;
    logic [8:0]    r_qx;
    logic [7:0]    r_qy;
    logic [8:0]    r_wx;
    logic [8:0]    r_wy;
    logic [7:0]    r_entry_lo;
    logic [7:0]    r_entry_hi;
    logic          r_out_valid;
    logic [7:0]    r_out;

    logic [3:0]                    recip_idx;
    logic [tbpf_pkg::RECIP_W-1:0]  recip;
    logic [4:0]                    bw_x, bw_y;
    logic [22:0]                   prod_x;
    logic [21:0]                   prod_y;
    logic [13:0]                   snap_x;
    logic [12:0]                   snap_y;
    logic [8:0]                    sum_x, sum_y;
    logic                          wide, tall;
    logic [1:0]                    block;
    logic [11:0]                   map_cell;
    logic [16:0]                   map_addr;
    logic                          flip_x_t, flip_y_t;
    logic [9:0]                    tile;
    logic [2:0]                    cx, cy;
    logic [15:0]                   tile_off;
    logic [16:0]                   tile_addr;
    logic [AW-1:0]                 rd_addr;
    logic                          high;
    logic [3:0]                    nib;
    logic [7:0]                    pixel;

    // mosaic: q = x / bw by reciprocal, snapped = q * bw; bw is 1 when off
    assign bw_x = i_cfg.mosaic_enable ? 5'(i_cfg.mosaic_size[3:0]) + 5'd1 : 5'd1;
    assign bw_y = i_cfg.mosaic_enable ? 5'(i_cfg.mosaic_size[7:4]) + 5'd1 : 5'd1;
    assign recip_idx = i_cfg.mosaic_enable ? i_cfg.mosaic_size[3:0] : 4'd0;
    assign recip  = tbpf_pkg::MOSAIC_RECIP[recip_idx];
    assign prod_x = 23'(r_px) * 23'(recip);
    assign prod_y = 22'(r_py) *
                    22'(tbpf_pkg::MOSAIC_RECIP[i_cfg.mosaic_enable ?
                                               i_cfg.mosaic_size[7:4] : 4'd0]);

    assign snap_x = 14'(r_qx) * 14'(bw_x);
    assign snap_y = 13'(r_qy) * 13'(bw_y);

    assign wide  = i_cfg.map_dims[0];
    assign tall  = i_cfg.map_dims[1];
    assign sum_x = snap_x[8:0] + i_cfg.scroll_x;
    assign sum_y = {1'b0, snap_y[7:0]} + i_cfg.scroll_y;

    // map entry address: 32x32 blocks of 2-byte entries
    assign block    = wide ? {r_wy[8], r_wx[8]} : {1'b0, r_wy[8]};
    assign map_cell = {block, r_wy[7:3], r_wx[7:3]};
    assign map_addr = {1'b0, i_cfg.screen_base, 11'd0} + {4'd0, map_cell, 1'b0};

    // tile byte address; high map byte arrives in r_rdata during the tile step
    assign flip_x_t = r_rdata[2];
    assign flip_y_t = r_rdata[3];
    assign tile     = {r_rdata[1:0], r_entry_lo};
    assign cx       = r_wx[2:0] ^ {3{flip_x_t}};
    assign cy       = r_wy[2:0] ^ {3{flip_y_t}};
    assign tile_off = i_cfg.pix8_mode ? {tile, cy, cx} : {1'b0, tile, cy, cx[2:1]};
    assign tile_addr = {1'b0, i_cfg.char_base, 14'd0} + {1'b0, tile_off};

    always_comb begin
        case (i_cmd.rd_sel)
            tbpf_pkg::RD_MAP_LO: rd_addr = wrap_addr(map_addr);
            tbpf_pkg::RD_MAP_HI: rd_addr = wrap_addr({map_addr[16:1], 1'b1});
            tbpf_pkg::RD_TILE:   rd_addr = wrap_addr(tile_addr);
            default:             rd_addr = wrap_addr(map_addr);
        endcase
    end

    // 4-bit mode: nibble chosen by x parity and x flip, zero is transparent
    assign high  = r_wx[0] ^ r_entry_hi[2];
    assign nib   = high ? r_rdata[7:4] : r_rdata[3:0];
    assign pixel = i_cfg.pix8_mode ? r_rdata :
                   (nib == 4'd0) ? 8'd0 : {r_entry_hi[7:4], nib};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wrap_addr(i_mem_address)] <= i_mem_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.mul_en) begin
            r_qx <= prod_x[21:13];
            r_qy <= prod_y[20:13];
        end
        if (i_cmd.snap_en) begin
            r_wx <= sum_x & {wide, 8'hFF};
            r_wy <= sum_y & {tall, 8'hFF};
        end
        if (i_cmd.lo_en) begin
            r_entry_lo <= r_rdata;
        end
        if (i_cmd.hi_en) begin
            r_entry_hi <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out <= pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pal_entry       = r_out;

endmodule

// ----- sv/tiled_background_pixel_fetch_unit.sv -----
// Tiled background layer pixel fetch unit: top level.
// Instantiates tbpf_cfg, tbpf_ctrl and tbpf_dp; depends on tbpf_pkg.
//
// Input channel (i_in_valid / o_in_ready) carries one word per item: a video
// memory byte write (operation 0) or a pixel fetch (operation 1).
// Output channel (o_out_valid / i_out_ready) returns one palette entry word
// per fetch; writes return nothing. The user must write the configuration
// registers (i_cfg_we / i_cfg_index / i_cfg_data) only while the unit is idle;
// the block does not enforce this. A write is stored at the accepting edge;
// the unit is ready again next cycle. A fetch passes through the accept cycle,
// one multiply step and one snap step for the mosaic grid, three dependent
// reads on the single read port of video memory (two map bytes, one tile
// byte), then the output load; the next item is accepted only after that
// load, so fetches do not overlap.
// A finished result waits in the output register while the next item is
// processed; only the output load of that item stalls while the previous
// word has not been taken.
// Reset clears configuration and the handshake state; video memory is not
// cleared and holds garbage until written.
module tiled_background_pixel_fetch_unit #(
    parameter int VRAM_BYTES = tbpf_pkg::VRAM_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [8:0]                        i_pixel_x,
    input  logic [7:0]                        i_pixel_y,
    input  logic [tbpf_pkg::MEM_ADDR_W-1:0]   i_mem_address,
    input  logic [7:0]                        i_mem_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_pal_entry,
    input  logic                              i_cfg_we,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tbpf_pkg::t_cfg    cfg;
    tbpf_pkg::t_cmd    cmd;
    tbpf_pkg::t_status status;

    tbpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tbpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tbpf_dp #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_mem_address   (i_mem_address),
        .i_mem_data      (i_mem_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pal_entry     (o_pal_entry)
    );

endmodule

// ----- sv/tbpf_checker.sv -----
// Port-level checker for the tiled background pixel fetch unit, bound to the top.
// Depends on tiled_background_pixel_fetch_unit_assert.svh.
`include "tiled_background_pixel_fetch_unit_assert.svh"

module tbpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_operation,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_pal_entry
);

    // stalled result word holds
    `TBPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pal_entry))

    // reset leaves the unit ready with no result pending
    `TBPF_ASSERT_NEXT(a_reset_state, i_clk, 1'b1, !i_rst_n, !o_out_valid && o_in_ready)

    // an accepted fetch occupies the unit
    `TBPF_ASSERT_NEXT(a_fetch_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_operation, !o_in_ready)

    // a new result is loaded only from the busy final step of a fetch
    `TBPF_ASSERT_IMPL(a_result_source, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind tiled_background_pixel_fetch_unit tbpf_checker u_tbpf_checker (.*);

// ----- tb/tb_tiled_background_pixel_fetch_unit.sv -----
// Self-checking testbench for tiled_background_pixel_fetch_unit: video memory writes and
// pixel fetches under several register settings and handshake idle patterns.
// Depends on tbpf_pkg and the unit's RTL; expected palette indexes come from a local model.
module tb_tiled_background_pixel_fetch_unit;

    localparam int VRAM_SIZE        = tbpf_pkg::VRAM_BYTES_DEF;
    localparam int MAP_BLOCK_BYTES  = 'h800;
    localparam int CHAR_BLOCK_BYTES = 'h4000;
    localparam int CELLS_PER_BLOCK  = 1024;
    localparam int TILE_COL_MASK    = 'h1F;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_WORDS      = 190;
    localparam int SETTLE_CYCLES    = 10;
    localparam int STALL_LIMIT      = 4000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic        op;
        logic [8:0]  px;
        logic [7:0]  py;
        logic [16:0] addr;
        logic [7:0]  data;
    } t_vram_word;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_ready;
    logic                            i_operation   = tbpf_pkg::OP_WRITE;
    logic [8:0]                      i_pixel_x     = '0;
    logic [7:0]                      i_pixel_y     = '0;
    logic [tbpf_pkg::MEM_ADDR_W-1:0] i_mem_address = '0;
    logic [7:0]                      i_mem_data    = '0;
    logic                            o_out_valid;
    logic                            i_out_ready   = 1'b0;
    logic [7:0]                      o_pal_entry;
    logic                            i_cfg_we      = 1'b0;
    logic [tbpf_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [tbpf_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    // model state: registers and the memory as the unit sees it
    tbpf_pkg::t_cfg model_cfg = '0;
    logic [7:0]  vram_model [VRAM_SIZE];
    // generator's view of memory, runs ahead of the unit
    logic [7:0]  plan_mem [VRAM_SIZE];
    bit          plan_written [VRAM_SIZE];

    t_vram_word  pending_words [$];
    logic [7:0]  expected_palette [$];
    t_idle_mode  idle_mode = IDLE_NONE;
    int          err_count = 0;
    int          writes_done = 0;
    int          fetches_done = 0;
    int          pixels_checked = 0;
    int          settings_loaded = 0;
    int          stall_cycles = 0;

    tiled_background_pixel_fetch_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_mem_address   (i_mem_address),
        .i_mem_data      (i_mem_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pal_entry     (o_pal_entry),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mosaic snap, scroll and wrap to the map size
    function automatic void scroll_wrap(input logic [8:0] px, input logic [7:0] py,
                                        output logic [8:0] mx, output logic [8:0] my);
        int x, y, bw, bh;
        x = px;
        y = py;
        if (model_cfg.mosaic_enable) begin
            bw = model_cfg.mosaic_size[3:0] + 1;
            bh = model_cfg.mosaic_size[7:4] + 1;
            x = x / bw * bw;
            y = y / bh * bh;
        end
        x = x + model_cfg.scroll_x;
        y = y + model_cfg.scroll_y;
        mx = model_cfg.map_dims[0] ? x[8:0] : {1'b0, x[7:0]};
        my = model_cfg.map_dims[1] ? y[8:0] : {1'b0, y[7:0]};
    endfunction

    function automatic logic [16:0] map_byte_addr(input logic [8:0] mx, input logic [8:0] my);
        int tx, ty, blk, cell_idx;
        tx = mx >> 3;
        ty = my >> 3;
        blk = (tx >> 5) + (ty >> 5) * (1 + model_cfg.map_dims[0]);
        cell_idx = blk * CELLS_PER_BLOCK + (tx & TILE_COL_MASK)
                   + ((ty & TILE_COL_MASK) << 5);
        return 17'(MAP_BLOCK_BYTES * model_cfg.screen_base + cell_idx * 2);
    endfunction

    // entry: tile 9..0, x flip 10, y flip 11, bank 15..12
    function automatic logic [16:0] tile_byte_addr(input logic [15:0] entry,
                                                   input logic [8:0] mx, input logic [8:0] my);
        int cx, cy, row_bytes, col;
        cx = mx[2:0];
        cy = my[2:0];
        if (entry[10]) cx = 7 - cx;
        if (entry[11]) cy = 7 - cy;
        row_bytes = 4 << model_cfg.pix8_mode;
        col = model_cfg.pix8_mode ? cx : cx >> 1;
        return 17'(CHAR_BLOCK_BYTES * model_cfg.char_base + entry[9:0] * row_bytes * 8
                   + col + cy * row_bytes);
    endfunction

    function automatic logic [7:0] palette_of(input logic [7:0] tbyte, input logic [15:0] entry,
                                              input logic [8:0] mx);
        logic [3:0] nib;
        if (model_cfg.pix8_mode) return tbyte;
        nib = (mx[0] ^ entry[10]) ? tbyte[7:4] : tbyte[3:0];
        if (nib == 4'd0) return 8'd0;
        return {entry[15:12], nib};
    endfunction

    function automatic bit gap_now(input bit receiver_side);
        case (idle_mode)
            IDLE_SENDER:   return !receiver_side && $urandom_range(99) < 77;
            IDLE_RECEIVER: return receiver_side && $urandom_range(99) < 77;
            IDLE_BOTH:     return $urandom_range(99) < 21;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic t_vram_word random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[42:0];
    endfunction

    task automatic queue_write(input logic [16:0] addr, input logic [7:0] data);
        t_vram_word w;
        w = random_word();
        w.op = tbpf_pkg::OP_WRITE;
        w.addr = addr;
        w.data = data;
        plan_mem[addr] = data;
        plan_written[addr] = 1'b1;
        pending_words.push_back(w);
    endtask

    // queues a fetch, preceded by whatever writes it needs so that it never reads
    // an unwritten byte; the given entry/byte are written when asked or when needed
    task automatic queue_fetch(input logic [8:0] px, input logic [7:0] py,
                               input bit new_entry, input logic [15:0] entry,
                               input bit new_byte, input logic [7:0] tbyte);
        logic [8:0]  mx, my;
        logic [16:0] ma, ta;
        t_vram_word  w;
        scroll_wrap(px, py, mx, my);
        ma = map_byte_addr(mx, my);
        if (new_entry || !plan_written[ma] || !plan_written[ma + 17'd1]) begin
            queue_write(ma, entry[7:0]);
            queue_write(ma + 17'd1, entry[15:8]);
        end
        ta = tile_byte_addr({plan_mem[ma + 17'd1], plan_mem[ma]}, mx, my);
        // tile byte sitting on its own map entry: leave it, the entry must stay
        if ((new_byte || !plan_written[ta]) && ta != ma && ta != ma + 17'd1)
            queue_write(ta, tbyte);
        w = random_word();
        w.op = tbpf_pkg::OP_FETCH;
        w.px = px;
        w.py = py;
        pending_words.push_back(w);
    endtask

    task automatic load_settings(input tbpf_pkg::t_cfg want);
        logic [tbpf_pkg::CFG_DATA_W-1:0] raw;
        for (int i = tbpf_pkg::CFG_CHAR_BASE; i <= tbpf_pkg::CFG_SCROLL_Y; i++) begin
            raw = tbpf_pkg::CFG_DATA_W'($urandom);    // unused upper bits carry junk
            case (tbpf_pkg::CFG_IDX_W'(i))
                tbpf_pkg::CFG_CHAR_BASE:     raw[1:0] = want.char_base;
                tbpf_pkg::CFG_SCREEN_BASE:   raw[4:0] = want.screen_base;
                tbpf_pkg::CFG_MAP_DIMS:      raw[1:0] = want.map_dims;
                tbpf_pkg::CFG_PIX8_MODE:     raw[0]   = want.pix8_mode;
                tbpf_pkg::CFG_MOSAIC_ENABLE: raw[0]   = want.mosaic_enable;
                tbpf_pkg::CFG_MOSAIC_SIZE:   raw[7:0] = want.mosaic_size;
                tbpf_pkg::CFG_SCROLL_X:      raw      = want.scroll_x;
                default:                     raw      = want.scroll_y;
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= tbpf_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= raw;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_cfg = want;
        settings_loaded++;
    endtask

    // sampled on the falling edge to stay clear of the driver's updates
    task automatic settle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_palette.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver: applies accepted words to the model, then offers the next word
    always @(posedge i_clk) begin : feed_proc
        logic [8:0]  mx, my;
        logic [16:0] ma;
        logic [15:0] ent;
        t_vram_word  w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_operation == tbpf_pkg::OP_WRITE) begin
                    vram_model[i_mem_address] = i_mem_data;
                    writes_done++;
                end else begin
                    scroll_wrap(i_pixel_x, i_pixel_y, mx, my);
                    ma = map_byte_addr(mx, my);
                    ent = {vram_model[ma + 17'd1], vram_model[ma]};
                    expected_palette.push_back(
                        palette_of(vram_model[tile_byte_addr(ent, mx, my)], ent, mx));
                    fetches_done++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && !gap_now(1'b0)) begin
                    w = pending_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_operation   <= w.op;
                    i_pixel_x     <= w.px;
                    i_pixel_y     <= w.py;
                    i_mem_address <= w.addr;
                    i_mem_data    <= w.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        logic [7:0] want_pal;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_palette.size() == 0) begin
                    $error("pal_entry: no word expected, got %0d", o_pal_entry);
                    err_count++;
                end else begin
                    want_pal = expected_palette.pop_front();
                    if (o_pal_entry !== want_pal) begin
                        $error("pal_entry: expected %0d, got %0d", want_pal, o_pal_entry);
                        err_count++;
                    end
                    pixels_checked++;
                end
            end
            i_out_ready <= !gap_now(1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        tbpf_pkg::t_cfg want;
        logic [8:0]     px;
        logic [7:0]     py;
        logic [7:0]     tb_byte;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiles kept apart from the map so forced entries stay intact
        want = '0;
        want.char_base = 2'd1;
        load_settings(want);
        queue_write(17'h1FFFF, 8'hFF);
        queue_write(17'h00000, 8'h00);
        queue_fetch(9'd0, 8'd0, 1'b1, 16'h0000, 1'b1, 8'h00);      // transparent nibble
        queue_fetch(9'd511, 8'd255, 1'b1, 16'hFFFF, 1'b1, 8'hFF);  // both flips, top tile, bank 15
        queue_fetch(9'd1, 8'd0, 1'b0, 16'h0000, 1'b1, 8'hA0);      // odd x takes the high nibble
        queue_fetch(9'd8, 8'd0, 1'b1, 16'h5401, 1'b1, 8'h3C);      // x flip
        queue_fetch(9'd16, 8'd9, 1'b1, 16'h2802, 1'b1, 8'h70);     // y flip
        queue_fetch(9'd0, 8'd0, 1'b0, 16'h0000, 1'b0, 8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == 0) begin
                want = '0;
            end else if (p == 1) begin
                want = '1;
            end else begin
                want.char_base     = $urandom_range(3);
                want.screen_base   = $urandom_range(31);
                want.map_dims      = $urandom_range(3);
                want.pix8_mode     = p[0];
                want.mosaic_enable = p[1];
                want.mosaic_size   = $urandom_range(255);
                want.scroll_x      = $urandom_range(511);
                want.scroll_y      = $urandom_range(511);
            end
            load_settings(want);
            idle_mode = t_idle_mode'(p % 4);
            while (pending_words.size() < PHASE_WORDS) begin
                if ($urandom_range(99) < 10) begin
                    queue_write(17'($urandom), 8'($urandom));
                end else begin
                    px = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 9'd511 : 9'd0)
                                                  : 9'($urandom);
                    py = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                                  : 8'($urandom);
                    tb_byte = 8'($urandom);
                    if ($urandom_range(3) == 0) tb_byte[3:0] = 4'd0;
                    if ($urandom_range(3) == 0) tb_byte[7:4] = 4'd0;
                    queue_fetch(px, py, $urandom_range(2) == 0, 16'($urandom),
                                $urandom_range(2) == 0, tb_byte);
                end
            end
        end
        settle();

        $display("Ran %0d memory writes and %0d pixel fetches, %0d palette indexes compared,",
                 writes_done, fetches_done, pixels_checked);
        $display("over %0d register settings and four handshake idle patterns.", settings_loaded);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tbpf_pkg.sv
sv/tbpf_cfg.sv
sv/tbpf_ctrl.sv
sv/tbpf_dp.sv
sv/tiled_background_pixel_fetch_unit.sv
sv/tbpf_checker.sv
tb/tb_tiled_background_pixel_fetch_unit.sv
